### sv/billboard_quad_vertex_generator_assert.svh
// ----------------------------------------------------------------------------
// billboard_quad_vertex_generator_assert
// Assertion macros for the billboard quad block.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_QUAD_VERTEX_GENERATOR_ASSERT_SVH
`define BILLBOARD_QUAD_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication
`define BQVG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqvg assertion failed");

// next-cycle implication
`define BQVG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bqvg assertion failed");

`endif

### sv/bqvg_pkg.sv
// ----------------------------------------------------------------------------
// bqvg_pkg
// Types, register codes and helpers of the billboard quad vertex generator.
// ----------------------------------------------------------------------------
package bqvg_pkg;

    localparam int CORNER_COUNT = 4;

    localparam logic [2:0] REG_SPRITE_W  = 3'd0;
    localparam logic [2:0] REG_SPRITE_H  = 3'd1;
    localparam logic [2:0] REG_SCALE_X   = 3'd2;
    localparam logic [2:0] REG_SCALE_Y   = 3'd3;
    localparam logic [2:0] REG_TEX_W     = 3'd4;
    localparam logic [2:0] REG_TEX_H     = 3'd5;
    localparam logic [2:0] REG_HAS_TEX   = 3'd6;

    localparam int SPRITE_W_RST = 16;
    localparam int SPRITE_H_RST = 16;
    localparam int SCALE_RST    = 256;
    localparam int TEX_W_RST    = 256;
    localparam int TEX_H_RST    = 256;
    localparam int RATE_X_RST   = (SPRITE_W_RST * 65536) / TEX_W_RST;
    localparam int RATE_Y_RST   = (SPRITE_H_RST * 65536) / TEX_H_RST;
    localparam int COUNT_RST    = TEX_W_RST / SPRITE_W_RST;

    localparam logic [23:0] UV_MAX = 24'hFFFFFF;
    localparam logic [1:0]  CORNER_LAST = 2'(CORNER_COUNT - 1);

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic [14:0]        ts;
        logic [14:0]        tc;
        logic [1:0]         qs;
        logic [1:0]         qc;
        logic [14:0]        z2s;
        logic [14:0]        z2c;
        logic [13:0]        ins;
        logic [13:0]        inc;
        logic [14:0]        mds;
        logic [14:0]        mdc;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        logic [28:0]        hwp;
        logic [28:0]        hhp;
        logic signed [45:0] pa;
        logic signed [45:0] pb;
        logic signed [45:0] pc;
        logic signed [45:0] pd;
        logic [12:0]        rem;
        logic [15:0]        dq;
        logic [41:0]        left;
        logic [44:0]        top;
        logic [23:0]        u_l;
        logic [23:0]        u_r;
        logic [23:0]        v_t;
        logic [23:0]        v_b;
    } item_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [39:0] rxv;
        logic signed [39:0] ryv;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic [23:0]        u;
        logic [23:0]        v;
    } rot_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [55:0] px;
        logic signed [55:0] py;
        logic signed [55:0] pz;
        logic signed [55:0] qx;
        logic signed [55:0] qy;
        logic signed [55:0] qz;
        logic [23:0]        u;
        logic [23:0]        v;
    } prod_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [23:0]        u;
        logic [23:0]        v;
    } vert_t;

    function automatic logic [23:0] sat_uv(input logic [45:0] val);
        logic [23:0] res;
        if (val > 46'(UV_MAX))
            res = UV_MAX;
        else
            res = val[23:0];
        return res;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [43:0] val);
        logic signed [31:0] res;
        if (val > 44'sh0007FFFFFFF)
            res = 32'sh7FFFFFFF;
        else if (val < -44'sh00080000000)
            res = -32'sh80000000;
        else
            res = val[31:0];
        return res;
    endfunction

    // one position coordinate from two products: round half up, add centre, clamp
    function automatic logic signed [31:0] place(input logic signed [31:0] ctr,
                                                 input logic signed [55:0] pr,
                                                 input logic signed [55:0] pu);
        logic signed [56:0] sum;
        logic signed [42:0] rs;
        logic signed [43:0] tot;
        sum = 57'(pr) + 57'(pu);
        rs  = 43'((sum + 57'sd8192) >>> 14);
        tot = 44'(ctr) + 44'(rs);
        return sat32(tot);
    endfunction

endpackage

### sv/billboard_quad_vertex_generator.sv
// ----------------------------------------------------------------------------
// billboard_quad_vertex_generator
// Camera-facing sprite quad: four rotated, placed and textured strip corners.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    centre, right and up axes, angle, frame_index
//  out       out_valid / out_stall  corner, vertex_x/y/z, tex_u/v, last_corner
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  An input word runs through a 19-stage front pipeline (sine, sizes, frame
//  divide one quotient bit per stage), then the corner hold register and a
//  3-stage corner pipeline. Four corners leave per word through the single
//  output channel, which sets the sustained rate.
//  After a register write, UV steps and frames per row are recomputed
//  by a shared one-bit-per-cycle divider; in_stall is high meanwhile.
//  Stalls freeze each pipeline as a whole; nothing is dropped or repeated.
module billboard_quad_vertex_generator #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      centre_x,
    input  logic signed [31:0]      centre_y,
    input  logic signed [31:0]      centre_z,
    input  logic signed [15:0]      right_x,
    input  logic signed [15:0]      right_y,
    input  logic signed [15:0]      right_z,
    input  logic signed [15:0]      up_x,
    input  logic signed [15:0]      up_y,
    input  logic signed [15:0]      up_z,
    input  logic [ANGLE_BITS-1:0]   angle,
    input  logic [15:0]             frame_index,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              corner,
    output logic signed [31:0]      vertex_x,
    output logic signed [31:0]      vertex_y,
    output logic signed [31:0]      vertex_z,
    output logic [23:0]             tex_u,
    output logic [23:0]             tex_v,
    output logic                    last_corner
);
    import bqvg_pkg::*;

    localparam int FRONT_DEPTH = 19;
    localparam int DIV_STAGES  = 16;
    localparam int STG_LAST    = FRONT_DEPTH - 1;

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RX   = 2'd1;
    localparam logic [1:0] DV_RY   = 2'd2;
    localparam logic [1:0] DV_CNT  = 2'd3;
    localparam logic [4:0] DV_LAST = 5'd29;

    // configuration registers
    logic [12:0] sprite_w_reg, sprite_h_reg, tex_w_reg, tex_h_reg;
    logic [15:0] scale_x_reg, scale_y_reg;
    logic        has_tex_reg;
    logic [28:0] rate_x_reg, rate_y_reg;
    logic [12:0] count_reg;

    // shared divider
    logic [1:0]  dv_state_reg, dv_state_next;
    logic [4:0]  dv_cnt_reg, dv_cnt_next;
    logic [12:0] dv_rem_reg, dv_rem_next;
    logic [28:0] dv_quo_reg, dv_quo_next;
    logic [28:0] dv_num;
    logic [12:0] dv_den;
    logic [13:0] dv_trial;
    logic        dv_ge;
    logic        dv_busy;
    logic        cfg_wr;

    // front pipeline
    item_t       pipe_reg  [FRONT_DEPTH];
    item_t       pipe_next [FRONT_DEPTH];
    logic [FRONT_DEPTH-1:0] vld_reg, vld_next;
    logic        front_en;
    logic [28:0] rate_x_eff, rate_y_eff;
    logic [12:0] count_eff;

    // corner expander and back pipeline
    item_t       hold_reg;
    logic        hold_v_reg;
    logic [1:0]  cnt_reg;
    logic        load_exp, emit, back_en;
    rot_t        b1_reg, b1_next;
    prod_t       b2_reg, b2_next;
    vert_t       out_reg, out_next;
    logic        b1_v_reg, b2_v_reg, out_v_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_w_reg <= 13'(SPRITE_W_RST);
            sprite_h_reg <= 13'(SPRITE_H_RST);
            scale_x_reg  <= 16'(SCALE_RST);
            scale_y_reg  <= 16'(SCALE_RST);
            tex_w_reg    <= 13'(TEX_W_RST);
            tex_h_reg    <= 13'(TEX_H_RST);
            has_tex_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_SPRITE_W: sprite_w_reg <= cfg_data[12:0];
                REG_SPRITE_H: sprite_h_reg <= cfg_data[12:0];
                REG_SCALE_X:  scale_x_reg  <= cfg_data;
                REG_SCALE_Y:  scale_y_reg  <= cfg_data;
                REG_TEX_W:    tex_w_reg    <= cfg_data[12:0];
                REG_TEX_H:    tex_h_reg    <= cfg_data[12:0];
                REG_HAS_TEX:  has_tex_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // operands of the current divide job; zero divisors count as one
    always_comb
    begin
        unique case (dv_state_reg)
            DV_RX:
            begin
                dv_num = {sprite_w_reg, 16'd0};
                dv_den = (tex_w_reg == 13'd0) ? 13'd1 : tex_w_reg;
            end
            DV_RY:
            begin
                dv_num = {sprite_h_reg, 16'd0};
                dv_den = (tex_h_reg == 13'd0) ? 13'd1 : tex_h_reg;
            end
            DV_CNT:
            begin
                dv_num = 29'(tex_w_reg);
                dv_den = (sprite_w_reg == 13'd0) ? 13'd1 : sprite_w_reg;
            end
            default:
            begin
                dv_num = '0;
                dv_den = 13'd1;
            end
        endcase
    end

    assign dv_busy  = (dv_state_reg != DV_IDLE);
    assign dv_trial = {dv_rem_reg, dv_quo_reg[28]};
    assign dv_ge    = (dv_trial >= {1'b0, dv_den});

    always_comb
    begin
        dv_state_next = dv_state_reg;
        dv_cnt_next   = dv_cnt_reg;
        dv_rem_next   = dv_rem_reg;
        dv_quo_next   = dv_quo_reg;
        if (dv_busy)
        begin
            if (dv_cnt_reg == 5'd0)
            begin
                dv_rem_next = '0;
                dv_quo_next = dv_num;
                dv_cnt_next = 5'd1;
            end
            else
            begin
                dv_rem_next = dv_ge ? 13'(dv_trial - {1'b0, dv_den}) : dv_trial[12:0];
                dv_quo_next = {dv_quo_reg[27:0], dv_ge};
                if (dv_cnt_reg == DV_LAST)
                begin
                    dv_cnt_next = 5'd0;
                    unique case (dv_state_reg)
                        DV_RX:   dv_state_next = DV_RY;
                        DV_RY:   dv_state_next = DV_CNT;
                        default: dv_state_next = DV_IDLE;
                    endcase
                end
                else
                    dv_cnt_next = dv_cnt_reg + 5'd1;
            end
        end
        // any write restarts the whole recompute
        if (cfg_wr)
        begin
            dv_state_next = DV_RX;
            dv_cnt_next   = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_state_reg <= DV_IDLE;
            dv_cnt_reg   <= '0;
            rate_x_reg   <= 29'(RATE_X_RST);
            rate_y_reg   <= 29'(RATE_Y_RST);
            count_reg    <= 13'(COUNT_RST);
        end
        else
        begin
            dv_state_reg <= dv_state_next;
            dv_cnt_reg   <= dv_cnt_next;
            if (dv_busy && !cfg_wr && dv_cnt_reg == DV_LAST)
            begin
                unique case (dv_state_reg)
                    DV_RX:   rate_x_reg <= dv_quo_next;
                    DV_RY:   rate_y_reg <= dv_quo_next;
                    default: count_reg  <= dv_quo_next[12:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg <= dv_rem_next;
        dv_quo_reg <= dv_quo_next;
    end

    assign rate_x_eff = has_tex_reg ? rate_x_reg : 29'd65536;
    assign rate_y_eff = has_tex_reg ? rate_y_reg : 29'd65536;
    assign count_eff  = (!has_tex_reg || count_reg == 13'd0) ? 13'd1 : count_reg;

    // ------------------------------------------------------------------ front
    assign front_en = !vld_reg[STG_LAST] || load_exp;
    assign in_stall = !front_en || dv_busy;

    always_comb
    begin
        item_t              it;
        logic [15:0]        ph_s;
        logic [15:0]        ph_c;
        logic [13:0]        trial;
        logic               ge;
        logic [29:0]        sq;
        logic [14:0]        smag;
        logic [15:0]        sv;
        logic signed [45:0] mw;
        logic signed [45:0] mh;
        logic signed [45:0] ms;
        logic signed [45:0] mc;

        trial = '0;
        ge    = 1'b0;
        sq    = '0;
        smag  = '0;
        sv    = '0;
        mw    = '0;
        mh    = '0;
        ms    = '0;
        mc    = '0;
        ph_s = 16'(16'(angle) << (16 - ANGLE_BITS));
        ph_c = ph_s + 16'd16384;
        it = '0;
        it.cx      = centre_x;
        it.cy      = centre_y;
        it.cz      = centre_z;
        it.right_x = right_x;
        it.right_y = right_y;
        it.right_z = right_z;
        it.up_x    = up_x;
        it.up_y    = up_y;
        it.up_z    = up_z;
        // fold the phase into a quarter wave
        it.qs = ph_s[15:14];
        it.qc = ph_c[15:14];
        it.ts = ph_s[14] ? 15'(15'd16384 - {1'b0, ph_s[13:0]}) : {1'b0, ph_s[13:0]};
        it.tc = ph_c[14] ? 15'(15'd16384 - {1'b0, ph_c[13:0]}) : {1'b0, ph_c[13:0]};
        it.dq = frame_index;
        pipe_next[0] = it;
        vld_next[0]  = in_valid && !dv_busy;

        for (int s = 1; s < FRONT_DEPTH; s++)
        begin
            it = pipe_reg[s-1];
            vld_next[s] = vld_reg[s-1];
            // frame / frames-per-row, one quotient bit per stage
            if (s <= DIV_STAGES)
            begin
                trial  = {it.rem, it.dq[15]};
                ge     = (trial >= {1'b0, count_eff});
                it.rem = ge ? 13'(trial - {1'b0, count_eff}) : trial[12:0];
                it.dq  = {it.dq[14:0], ge};
            end
            if (s == 1)
            begin
                it.z2s = 15'((30'(it.ts) * 30'(it.ts)) >> 14);
                it.z2c = 15'((30'(it.tc) * 30'(it.tc)) >> 14);
                it.hwp = 29'(sprite_w_reg) * 29'(scale_x_reg);
                it.hhp = 29'(sprite_h_reg) * 29'(scale_y_reg);
            end
            if (s == 2)
            begin
                it.ins = 14'(14'd10512 - 14'((26'(it.z2s) * 26'd1160) >> 14));
                it.inc = 14'(14'd10512 - 14'((26'(it.z2c) * 26'd1160) >> 14));
            end
            if (s == 3)
            begin
                it.mds = 15'(15'd25736 - 15'((29'(it.z2s) * 29'(it.ins)) >> 14));
                it.mdc = 15'(15'd25736 - 15'((29'(it.z2c) * 29'(it.inc)) >> 14));
            end
            if (s == 4)
            begin
                sq    = (30'(it.ts) * 30'(it.mds)) >> 14;
                smag  = (sq > 30'd16384) ? 15'd16384 : sq[14:0];
                sv    = {1'b0, smag};
                it.sn = it.qs[1] ? $signed(16'(-sv)) : $signed(sv);
                sq    = (30'(it.tc) * 30'(it.mdc)) >> 14;
                smag  = (sq > 30'd16384) ? 15'd16384 : sq[14:0];
                sv    = {1'b0, smag};
                it.cs = it.qc[1] ? $signed(16'(-sv)) : $signed(sv);
            end
            if (s == 5)
            begin
                mw    = $signed({17'd0, it.hwp});
                mh    = $signed({17'd0, it.hhp});
                ms    = 46'(it.sn);
                mc    = 46'(it.cs);
                it.pa = mw * mc;
                it.pb = mh * ms;
                it.pc = mh * mc;
                it.pd = mw * ms;
            end
            if (s == DIV_STAGES + 1)
            begin
                it.left = 42'(rate_x_eff) * 42'(it.rem);
                it.top  = 45'(rate_y_eff) * 45'(it.dq);
            end
            if (s == DIV_STAGES + 2)
            begin
                it.u_l = sat_uv(46'(it.left));
                it.u_r = sat_uv(46'(it.left) + 46'(rate_x_eff));
                it.v_t = sat_uv(46'(it.top));
                it.v_b = sat_uv(46'(it.top) + 46'(rate_y_eff));
            end
            pipe_next[s] = it;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (front_en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
            pipe_reg <= pipe_next;
    end

    // ------------------------------------------------------------ expander
    assign back_en  = !out_v_reg || !out_stall;
    assign emit     = hold_v_reg && back_en;
    assign load_exp = vld_reg[STG_LAST] &&
                      (!hold_v_reg || (cnt_reg == CORNER_LAST && back_en));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (load_exp)
            begin
                hold_v_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (emit)
            begin
                if (cnt_reg == CORNER_LAST)
                    hold_v_reg <= 1'b0;
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_exp)
            hold_reg <= pipe_reg[STG_LAST];
    end

    // ------------------------------------------------------------ back end
    always_comb
    begin
        logic signed [46:0] vx;
        logic signed [46:0] vy;
        // rx = sx*A + sy*B, ry = sy*C - sx*D, then /128 rounding half up
        vx = (cnt_reg[0] ? 47'(hold_reg.pa) : -47'(hold_reg.pa))
           + (cnt_reg[1] ? -47'(hold_reg.pb) : 47'(hold_reg.pb));
        vy = (cnt_reg[1] ? -47'(hold_reg.pc) : 47'(hold_reg.pc))
           - (cnt_reg[0] ? 47'(hold_reg.pd) : -47'(hold_reg.pd));
        b1_next.corner  = cnt_reg;
        b1_next.rxv     = 40'((vx + 47'sd64) >>> 7);
        b1_next.ryv     = 40'((vy + 47'sd64) >>> 7);
        b1_next.cx      = hold_reg.cx;
        b1_next.cy      = hold_reg.cy;
        b1_next.cz      = hold_reg.cz;
        b1_next.right_x = hold_reg.right_x;
        b1_next.right_y = hold_reg.right_y;
        b1_next.right_z = hold_reg.right_z;
        b1_next.up_x    = hold_reg.up_x;
        b1_next.up_y    = hold_reg.up_y;
        b1_next.up_z    = hold_reg.up_z;
        b1_next.u       = cnt_reg[0] ? hold_reg.u_r : hold_reg.u_l;
        b1_next.v       = cnt_reg[1] ? hold_reg.v_b : hold_reg.v_t;
    end

    always_comb
    begin
        b2_next.corner = b1_reg.corner;
        b2_next.cx     = b1_reg.cx;
        b2_next.cy     = b1_reg.cy;
        b2_next.cz     = b1_reg.cz;
        b2_next.px     = 56'(b1_reg.right_x) * 56'(b1_reg.rxv);
        b2_next.py     = 56'(b1_reg.right_y) * 56'(b1_reg.rxv);
        b2_next.pz     = 56'(b1_reg.right_z) * 56'(b1_reg.rxv);
        b2_next.qx     = 56'(b1_reg.up_x) * 56'(b1_reg.ryv);
        b2_next.qy     = 56'(b1_reg.up_y) * 56'(b1_reg.ryv);
        b2_next.qz     = 56'(b1_reg.up_z) * 56'(b1_reg.ryv);
        b2_next.u      = b1_reg.u;
        b2_next.v      = b1_reg.v;
    end

    always_comb
    begin
        out_next.corner = b2_reg.corner;
        out_next.vx     = place(b2_reg.cx, b2_reg.px, b2_reg.qx);
        out_next.vy     = place(b2_reg.cy, b2_reg.py, b2_reg.qy);
        out_next.vz     = place(b2_reg.cz, b2_reg.pz, b2_reg.qz);
        out_next.u      = b2_reg.u;
        out_next.v      = b2_reg.v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (back_en)
        begin
            b1_v_reg  <= emit;
            b2_v_reg  <= b1_v_reg;
            out_v_reg <= b2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            out_reg <= out_next;
        end
    end

    assign out_valid   = out_v_reg;
    assign corner      = out_reg.corner;
    assign vertex_x    = out_reg.vx;
    assign vertex_y    = out_reg.vy;
    assign vertex_z    = out_reg.vz;
    assign tex_u       = out_reg.u;
    assign tex_v       = out_reg.v;
    assign last_corner = (out_reg.corner == CORNER_LAST);

    // ---------------------------------------------------------- assertions
    `include "billboard_quad_vertex_generator_assert.svh"

    `BQVG_ASSERT_IMP(a_no_accept_while_dividing, in_valid && !in_stall, dv_state_reg == DV_IDLE)
    `BQVG_ASSERT_NEXT(a_front_tail_held, !front_en && vld_reg[STG_LAST], vld_reg[STG_LAST] && $stable(pipe_reg[STG_LAST]))
    `BQVG_ASSERT_NEXT(a_quad_not_cut, emit && cnt_reg != CORNER_LAST, hold_v_reg)

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the billboard quad vertex generator. Sprites go in
// on a valid/stall channel and an in-bench model predicts the four strip
// corners of each. The corners are compared in order, field by field. The run
// covers register sweeps, directed extremes, random traffic under several
// idle mixes, and a long output hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb;
    import bqvg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_NONE = 3'd7;   // no register at this index
    localparam int STUCK_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [31:0] cx, cy, cz;
        logic signed [15:0] rx, ry, rz;
        logic signed [15:0] ux, uy, uz;
        logic [11:0]        ang;
        logic [15:0]        frame;
    } sprite_t;

    typedef struct {
        logic [1:0]         corner;
        logic signed [31:0] vx, vy, vz;
        logic [23:0]        u, v;
        logic               last;
    } corner_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] centre_x = '0, centre_y = '0, centre_z = '0;
    logic signed [15:0] right_x = '0, right_y = '0, right_z = '0;
    logic signed [15:0] up_x = '0, up_y = '0, up_z = '0;
    logic [11:0] angle = '0;
    logic [15:0] frame_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] corner;
    logic signed [31:0] vertex_x, vertex_y, vertex_z;
    logic [23:0] tex_u, tex_v;
    logic last_corner;

    // register shadow
    longint sw_r = 16, sh_r = 16, scx_r = 256, scy_r = 256;
    longint tw_r = 256, th_r = 256, tex_r = 0;

    corner_t expected_corners[$];
    int errors = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int hold_left = 0;

    always #4 clk = ~clk;

    billboard_quad_vertex_generator u_top (.*);

    // ---------------- predictor ----------------
    function automatic longint quarter_wave(longint t);
        longint z2, ip, md, s;
        z2 = (t * t) >> 14;
        ip = 10512 - ((z2 * 1160) >> 14);
        md = 25736 - ((z2 * ip) >> 14);
        s = (t * md) >> 14;
        return (s > 16384) ? 16384 : s;
    endfunction

    function automatic longint sine_q14(longint phase);
        longint p, r, s;
        p = phase & 'hFFFF;
        r = p & 'h3FFF;
        s = ((p >> 14) & 1) ? quarter_wave(16384 - r) : quarter_wave(r);
        return ((p >> 15) & 1) ? -s : s;
    endfunction

    function automatic longint round14(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [23:0] clamp_uv(longint v);
        return (v > 16777215) ? 24'hFFFFFF : v[23:0];
    endfunction

    task automatic predict_quad(input sprite_t s);
        longint sn, cs, hw, hh, rate_x, rate_y, cnt, lft, top, ox, oy, rx, ry;
        longint frm;
        corner_t c;
        sn = sine_q14(longint'(s.ang) << 4);
        cs = sine_q14((longint'(s.ang) << 4) + 16384);
        hw = (sw_r * scx_r) << 7;
        hh = (sh_r * scy_r) << 7;
        frm = s.frame;
        if (tex_r != 0)
        begin
            rate_x = (sw_r << 16) / ((tw_r != 0) ? tw_r : 1);
            rate_y = (sh_r << 16) / ((th_r != 0) ? th_r : 1);
            cnt = tw_r / ((sw_r != 0) ? sw_r : 1);
            if (cnt == 0)
                cnt = 1;
        end
        else
        begin
            rate_x = 65536;
            rate_y = 65536;
            cnt = 1;
        end
        lft = rate_x * (frm % cnt);
        top = rate_y * (frm / cnt);
        for (int k = 0; k < 4; k++)
        begin
            ox = (k & 1) ? hw : -hw;
            oy = (k & 2) ? -hh : hh;
            rx = round14(ox * cs + oy * sn);
            ry = round14(oy * cs - ox * sn);
            c.corner = 2'(k);
            c.vx = clamp32(longint'(s.cx) + round14(longint'(s.rx) * rx + longint'(s.ux) * ry));
            c.vy = clamp32(longint'(s.cy) + round14(longint'(s.ry) * rx + longint'(s.uy) * ry));
            c.vz = clamp32(longint'(s.cz) + round14(longint'(s.rz) * rx + longint'(s.uz) * ry));
            c.u = clamp_uv((k & 1) ? lft + rate_x : lft);
            c.v = clamp_uv((k & 2) ? top + rate_y : top);
            c.last = (k == 3);
            expected_corners.push_back(c);
        end
    endtask

    // ---------------- checker ----------------
    task automatic compare(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d actual %0d", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        corner_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_corners.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: corner %0d", corner);
            end
            else
            begin
                e = expected_corners.pop_front();
                compare("corner", e.corner, corner);
                compare("vertex_x", e.vx, vertex_x);
                compare("vertex_y", e.vy, vertex_y);
                compare("vertex_z", e.vz, vertex_z);
                compare("tex_u", e.u, tex_u);
                compare("tex_v", e.v, tex_v);
                compare("last_corner", e.last, last_corner);
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    // watchdog on cycles with no handshake at all
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready) || !rst_n)
                stuck = 0;
            else
                stuck++;
        end
        $display("timeout");
        $display("Verification failed");
        $finish;
    end

    // ---------------- stimulus helpers ----------------
    task automatic wait_drained();
        while (expected_corners.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_index = idx;
        cfg_data = 16'(val);
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            REG_SPRITE_W: sw_r = val & 'h1FFF;
            REG_SPRITE_H: sh_r = val & 'h1FFF;
            REG_SCALE_X:  scx_r = val & 'hFFFF;
            REG_SCALE_Y:  scy_r = val & 'hFFFF;
            REG_TEX_W:    tw_r = val & 'h1FFF;
            REG_TEX_H:    th_r = val & 'h1FFF;
            REG_HAS_TEX:  tex_r = val & 1;
            default: ;
        endcase
    endtask

    task automatic setup(input int sw, input int sh, input int sx, input int sy,
                         input int tw, input int th, input int tx);
        wait_drained();
        write_reg(REG_SPRITE_W, sw);
        write_reg(REG_SPRITE_H, sh);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_TEX_W, tw);
        write_reg(REG_TEX_H, th);
        write_reg(REG_HAS_TEX, tx);
    endtask

    task automatic send_sprite(input sprite_t s);
        // idle cycle by cycle at the chosen rate
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        {centre_x, centre_y, centre_z} = {s.cx, s.cy, s.cz};
        {right_x, right_y, right_z} = {s.rx, s.ry, s.rz};
        {up_x, up_y, up_z} = {s.ux, s.uy, s.uz};
        angle = s.ang;
        frame_index = s.frame;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_quad(s);
        @(negedge clk);
    endtask

    task automatic finish_burst();
        in_valid = 1'b0;
    endtask

    function automatic sprite_t random_sprite();
        sprite_t s;
        bit wide;
        wide = ($urandom_range(0, 3) == 0);
        s.cx = wide ? $urandom : $signed(32'($urandom_range(0, 'h3FFFFF))) - 'sh200000;
        s.cy = wide ? $urandom : $signed(32'($urandom_range(0, 'h3FFFFF))) - 'sh200000;
        s.cz = wide ? $urandom : $signed(32'($urandom_range(0, 'h3FFFFF))) - 'sh200000;
        {s.rx, s.ry, s.rz} = {16'($urandom), 16'($urandom), 16'($urandom)};
        {s.ux, s.uy, s.uz} = {16'($urandom), 16'($urandom), 16'($urandom)};
        s.ang = 12'($urandom_range(0, 4095));
        s.frame = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 40));
        return s;
    endfunction

    function automatic sprite_t fixed_sprite(input longint c, input int ax, input int ang,
                                             input int frm);
        sprite_t s;
        s.cx = 32'(c);  s.cy = 32'(-c);  s.cz = 32'(c);
        s.rx = 16'(ax); s.ry = 16'(-ax); s.rz = 16'sd0;
        s.ux = 16'sd0; s.uy = 16'(ax); s.uz = 16'(-ax);
        s.ang = 12'(ang);
        s.frame = 16'(frm);
        return s;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        int angles[6] = '{0, 512, 1024, 2048, 3072, 4095};
        foreach (angles[i])
            send_sprite(fixed_sprite(0, 16384, angles[i], i));
        // position saturation both ways, extreme axes
        send_sprite(fixed_sprite(64'sd2147483647, -32768, 100, 65535));
        send_sprite(fixed_sprite(-64'sd2147483648, 32767, 3000, 0));
        send_sprite(fixed_sprite(-64'sd2147483648, -32768, 1024, 65535));
        finish_burst();
        // sheet bound, then sprite wider than the sheet with huge sizes
        setup(16, 16, 256, 256, 256, 256, 1);
        send_sprite(fixed_sprite(65536, 16384, 0, 0));
        send_sprite(fixed_sprite(65536, 16384, 700, 17));
        send_sprite(fixed_sprite(65536, 16384, 1500, 65535));
        finish_burst();
        setup(4096, 4096, 65535, 65535, 1, 1, 1);
        send_sprite(fixed_sprite(0, 32767, 256, 65535));
        send_sprite(fixed_sprite(64'sd2147483647, -32768, 0, 1));
        finish_burst();
        // zero sizes used as divisors
        setup(0, 0, 0, 0, 0, 0, 1);
        send_sprite(fixed_sprite(12345, 16384, 333, 65535));
        send_sprite(fixed_sprite(-12345, -16384, 4000, 3));
        finish_burst();
        setup(1, 1, 1, 65535, 4096, 4096, 1);
        send_sprite(fixed_sprite(777, 16384, 2000, 65535));
        send_sprite(fixed_sprite(777, 16384, 2000, 4097));
        finish_burst();
        // unknown index must not disturb anything
        wait_drained();
        write_reg(REG_NONE, 16'hFFFF);
        send_sprite(fixed_sprite(777, 16384, 2000, 4097));
        finish_burst();
    endtask

    task automatic random_setup();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            setup($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(0, 1));
        else
            setup($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(64, 1024),
                  $urandom_range(64, 1024), $urandom_range(1, 1024), $urandom_range(1, 1024),
                  (pick != 1));
    endtask

    task automatic test_random(input int in_pct, input int out_pct, input int count);
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
            begin
                finish_burst();
                random_setup();
            end
            send_sprite(random_sprite());
        end
        finish_burst();
    endtask

    task automatic test_backpressure();
        in_idle_pct = 0;
        out_idle_pct = 0;
        hold_left = 500;
        for (int i = 0; i < 30; i++)
            send_sprite(random_sprite());
        finish_burst();
        // sender pauses until every corner is back
        wait_drained();
        for (int i = 0; i < 10; i++)
            send_sprite(random_sprite());
        finish_burst();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(27, 57, 100);
        test_random(57, 27, 100);
        test_random(0, 0, 100);
        test_backpressure();
        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### billboard_quad_vertex_generator.f
+incdir+sv
sv/bqvg_pkg.sv
sv/billboard_quad_vertex_generator.sv
verif/tb.sv
